[hw/rtl/fixed_frame_sync_crc8_check_unit_defines.svh]
// ----------------------------------------------------------------------------
// Frame sync CRC-8 check unit: assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef FIXED_FRAME_SYNC_CRC8_CHECK_UNIT_DEFINES_SVH
`define FIXED_FRAME_SYNC_CRC8_CHECK_UNIT_DEFINES_SVH

// Same-cycle implication.
`define FFSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FFSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/ffsc_pkg.sv]
// ----------------------------------------------------------------------------
// ffsc_pkg
// Constants, types and CRC helpers for the frame sync CRC-8 check unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffsc_pkg;

    localparam int unsigned FRAME_BYTES   = 16;
    localparam int unsigned WIN_LEN       = (FRAME_BYTES < 5) ? 5 :
                                            ((FRAME_BYTES > 16) ? 16 : FRAME_BYTES);
    localparam int unsigned CRC_POS       = WIN_LEN - 2;
    localparam int unsigned PAYLOAD_COUNT = 12;
    localparam int unsigned FILL_W        = $clog2(WIN_LEN + 1);

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_TOP  = 8'h80;
    localparam logic [7:0] CRC_INIT = 8'h00;

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WIN_LEN);
    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(WIN_LEN - 1);

    typedef logic [7:0]      t_byte;
    typedef logic [7:0][7:0] t_cols;   // one CRC column per input bit

    typedef enum logic [0:0] {
        CFG_START_BYTE = 1'b0,
        CFG_END_BYTE   = 1'b1
    } t_cfg_idx;

    // One MSB-first CRC-8 bit step.
    function automatic t_byte crc_step(input t_byte acc);
        t_byte res;
        if ((acc & CRC_TOP) != 8'h00) begin
            res = {acc[6:0], 1'b0} ^ CRC_POLY;
        end else begin
            res = {acc[6:0], 1'b0};
        end
        return res;
    endfunction

    // Columns of the linear map byte -> CRC of that byte followed by
    // 'zeros' zero bytes. Only called with constants (elaboration time).
    function automatic t_cols crc_cols(input int unsigned zeros);
        t_cols cols;
        t_byte acc;
        for (int j = 0; j < 8; j++) begin
            acc = 8'(1 << j);
            for (int s = 0; s < 8 * (zeros + 1); s++) begin
                acc = crc_step(acc);
            end
            cols[j] = acc;
        end
        return cols;
    endfunction

endpackage

[hw/rtl/ffsc_cell.sv]
// ----------------------------------------------------------------------------
// ffsc_cell
// One window byte plus its registered CRC contribution for the next slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffsc_cell
    import ffsc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_shift,
    input  t_byte i_byte,
    input  t_cols i_cols,
    output t_byte o_byte,
    output t_byte o_contrib
);

    t_byte r_byte;
    t_byte r_contrib;
    t_byte n_contrib;

    // GF(2) matrix times the incoming byte
    always_comb begin
        n_contrib = 8'h00;
        for (int j = 0; j < 8; j++) begin
            if (i_byte[j]) begin
                n_contrib = n_contrib ^ i_cols[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte    <= i_byte;
            r_contrib <= n_contrib;
        end
    end

    assign o_byte    = r_byte;
    assign o_contrib = r_contrib;

endmodule

[hw/rtl/fixed_frame_sync_crc8_check_unit.sv]
// ----------------------------------------------------------------------------
// fixed_frame_sync_crc8_check_unit
// Sliding-window frame finder with CRC-8 (poly 0x31) check on each frame.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_rx_byte, i_burst_end
//  out     | output    | o_out_valid / i_out_ready | o_frame_status, o_command_byte,
//          |           |                           | o_payload_low, o_payload_high
//  cfg     | input     | i_cfg_we (no wait)        | i_cfg_idx, i_cfg_data
//
//  One byte per cycle while o_in_ready is high. A frame result appears in the output register the
//  cycle after the transfer of its end byte.
//  The window is a row of byte cells that shift on every input transfer;
//  each cell keeps the CRC contribution of its byte for the slot it moves
//  into next, so the check is a XOR of registered bytes.
//  o_in_ready drops only while a result sits in the output register and
//  i_out_ready is low.
//  Reset (synchronous, active low) empties the window, clears the output
//  valid flag and sets both match bytes to zero.
//
`timescale 1ns / 1ps
`include "fixed_frame_sync_crc8_check_unit_defines.svh"

module fixed_frame_sync_crc8_check_unit
    import ffsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input byte channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_burst_end,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_frame_status,
    output logic [7:0]  o_command_byte,
    output logic [63:0] o_payload_low,
    output logic [31:0] o_payload_high,
    // configuration
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    t_byte r_start_byte;
    t_byte r_end_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= 8'h00;
            r_end_byte   <= 8'h00;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_START_BYTE: r_start_byte <= i_cfg_data;
                CFG_END_BYTE:   r_end_byte   <= i_cfg_data;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Window: newest byte enters the top cell, oldest leaves cell 0.
    // With k valid bytes they sit in the top k cells, oldest lowest,
    // so a full window lines up with frame positions 0..WIN_LEN-1.
    // ---------------------------------------------------------------
    logic                        w_in_xfer;
    t_byte [WIN_LEN-1:0]         w_byte;
    t_byte [WIN_LEN-1:0]         w_contrib;

    assign w_in_xfer = i_in_valid && o_in_ready;

    for (genvar k = 0; k < WIN_LEN; k++) begin : g_cell
        // cell k moves to slot k-1 on the next shift; only slots that
        // feed the CRC get a nonzero map
        localparam t_cols CELL_COLS =
            (k >= 1 && k <= CRC_POS) ? crc_cols(CRC_POS - k) : '0;
        t_byte w_feed;

        if (k == WIN_LEN - 1) begin : g_top
            assign w_feed = i_rx_byte;
        end else begin : g_mid
            assign w_feed = w_byte[k+1];
        end

        ffsc_cell u_cell (
            .i_clk     (i_clk),
            .i_shift   (w_in_xfer),
            .i_byte    (w_feed),
            .i_cols    (CELL_COLS),
            .o_byte    (w_byte[k]),
            .o_contrib (w_contrib[k])
        );
    end

    // ---------------------------------------------------------------
    // Match on the window as it stands after this byte is shifted in:
    // frame slot p is cell p+1 now, the last slot is the incoming byte.
    // ---------------------------------------------------------------
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic              w_full_next;
    logic              w_match;
    t_byte             w_crc;

    assign w_full_next = (r_fill >= FILL_LAST);
    assign w_match     = w_full_next && (w_byte[1] == r_start_byte) &&
                         (i_rx_byte == r_end_byte);

    always_comb begin
        w_crc = CRC_INIT;
        for (int k = 1; k <= CRC_POS; k++) begin
            w_crc = w_crc ^ w_contrib[k];
        end
    end

    // payload slots at or past the CRC byte read as zero on short frames
    t_byte [PAYLOAD_COUNT-1:0] w_pay;

    for (genvar i = 0; i < PAYLOAD_COUNT; i++) begin : g_pay
        if (i + 2 < CRC_POS) begin : g_on
            assign w_pay[i] = w_byte[i+3];
        end else begin : g_off
            assign w_pay[i] = 8'h00;
        end
    end

    // fill count: a found frame or a burst end empties the window
    always_comb begin
        n_fill = r_fill;
        if (w_in_xfer) begin
            priority if (w_match || i_burst_end) begin
                n_fill = '0;
            end else if (r_fill == FILL_FULL) begin
                n_fill = FILL_FULL;
            end else begin
                n_fill = r_fill + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    logic         r_out_valid;
    logic         r_status;
    t_byte        r_command;
    logic [63:0]  r_pay_low;
    logic [31:0]  r_pay_high;

    assign o_in_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_xfer && w_match) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer && w_match) begin
            r_status   <= (w_crc != w_byte[WIN_LEN-1]);
            r_command  <= w_byte[2];
            r_pay_low  <= w_pay[7:0];
            r_pay_high <= w_pay[PAYLOAD_COUNT-1:8];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_frame_status = r_status;
    assign o_command_byte = r_command;
    assign o_payload_low  = r_pay_low;
    assign o_payload_high = r_pay_high;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `FFSC_ASSERT_NOW(a_fill_bound, 1'b1, r_fill <= FILL_FULL,
        "window fill count past window length")
    `FFSC_ASSERT_NEXT(a_match_emits, w_in_xfer && w_match,
        r_out_valid && r_fill == '0, "found frame not emitted or window not emptied")
    `FFSC_ASSERT_NEXT(a_burst_clears, w_in_xfer && i_burst_end,
        r_fill == '0, "window not emptied after burst end")
    `FFSC_ASSERT_NEXT(a_fill_step,
        w_in_xfer && !w_match && !i_burst_end && r_fill != FILL_FULL,
        r_fill == $past(r_fill) + FILL_W'(1), "fill count did not advance")

endmodule
